// File: rtl/csp_pkg.sv
// Shared types and constants for the cosine similarity percent block.
// Used by the accumulator, the shared adder, the sequencer and the top level.
// Depends on nothing.
package csp_pkg;

  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 48;
  localparam int SCALE_W = ACC_W + 8;
  localparam int WIDE_W  = 2 * SCALE_W;
  localparam int NORM_W  = 2 * ACC_W;
  localparam int CNT_W   = $clog2(SCALE_W);
  localparam int CODE_W  = 8;

  localparam int PERCENT_LIMIT = 100;
  localparam int STEP_W        = $clog2(PERCENT_LIMIT + 1);

  localparam int SCALE_STEPS    = 3;
  localparam int SCALE_SHIFT_HI = 7;
  localparam int SCALE_SHIFT_MD = 6;
  localparam int SCALE_SHIFT_LO = 3;
  localparam int STEP_SHIFT     = 3;

  localparam logic [CODE_W-1:0] CODE_OFFSET = 8'd128;
  localparam logic [CODE_W-1:0] CODE_MIN    = 8'd28;
  localparam logic [CODE_W-1:0] CODE_MAX    = 8'd228;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE,
    ST_SQUARE,
    ST_NORM,
    ST_COMPARE,
    ST_STEP_Q,
    ST_STEP_S,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic              valid;
    logic [ACC_W-1:0]  dot;
    logic [ACC_W-1:0]  norm_a;
    logic [ACC_W-1:0]  norm_b;
  } sums_t;

  typedef struct packed {
    logic [WIDE_W-1:0] opa;
    logic [WIDE_W-1:0] opb;
    logic              sub;
  } alu_req_t;

endpackage

// File: rtl/csp_in_if.sv
// Request channel carrying one element pair of the two vectors.
// Depends on csp_pkg for the element width.
interface csp_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [csp_pkg::ELEM_W-1:0]   first_element;
  logic signed [csp_pkg::ELEM_W-1:0]   second_element;
  logic                                last;

  modport source(output valid, first_element, second_element, last, input ready);
  modport sink(input valid, first_element, second_element, last, output ready);
endinterface

// File: rtl/csp_out_if.sv
// Result channel carrying the similarity code of one vector pair.
// Depends on csp_pkg for the code width.
interface csp_out_if;
  logic                         valid;
  logic                         ready;
  logic [csp_pkg::CODE_W-1:0]   similarity_code;
  logic                         zero_dot;

  modport source(output valid, similarity_code, zero_dot, input ready);
  modport sink(input valid, similarity_code, zero_dot, output ready);
endinterface

// File: rtl/csp_accum.sv
// Two-stage element pipeline: registered products, then the dot and norm sums.
// Hands the final sums to the sequencer on the last pair and clears itself.
// Depends on csp_pkg.
module csp_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic signed [csp_pkg::ELEM_W-1:0]  first_element,
  input  logic signed [csp_pkg::ELEM_W-1:0]  second_element,
  input  logic                               last,
  output csp_pkg::sums_t                     sums
);
  localparam int AW = csp_pkg::ACC_W;
  localparam int PW = csp_pkg::PROD_W;

  logic                 v1;
  logic                 last1;
  logic signed [PW-1:0] prod_ab;
  logic [PW-1:0]        prod_aa;
  logic [PW-1:0]        prod_bb;
  logic [AW-1:0]        dot;
  logic [AW-1:0]        norm_a;
  logic [AW-1:0]        norm_b;
  logic [AW-1:0]        dot_sum;
  logic [AW-1:0]        norm_a_sum;
  logic [AW-1:0]        norm_b_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      last1 <= 1'b0;
    end else begin
      v1    <= take;
      last1 <= take && last;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_ab <= first_element * second_element;
      prod_aa <= first_element * first_element;
      prod_bb <= second_element * second_element;
    end
  end

  assign dot_sum    = dot + {{(AW-PW){prod_ab[PW-1]}}, prod_ab};
  assign norm_a_sum = norm_a + {{(AW-PW){1'b0}}, prod_aa};
  assign norm_b_sum = norm_b + {{(AW-PW){1'b0}}, prod_bb};

  always_ff @(posedge clk) begin
    if (rst) begin
      dot    <= '0;
      norm_a <= '0;
      norm_b <= '0;
    end else if (v1) begin
      if (last1) begin
        dot    <= '0;
        norm_a <= '0;
        norm_b <= '0;
      end else begin
        dot    <= dot_sum;
        norm_a <= norm_a_sum;
        norm_b <= norm_b_sum;
      end
    end
  end

  assign sums.valid  = v1 && last1;
  assign sums.dot    = dot_sum;
  assign sums.norm_a = norm_a_sum;
  assign sums.norm_b = norm_b_sum;

endmodule

// File: rtl/csp_alu.sv
// Shared wide adder and subtracter used for every step of the final evaluation.
// The carry out is high on a subtraction when no borrow occurs.
// Depends on csp_pkg.
module csp_alu (
  input  csp_pkg::alu_req_t               req,
  output logic [csp_pkg::WIDE_W-1:0]      sum,
  output logic                            carry
);
  localparam int WW = csp_pkg::WIDE_W;

  logic [WW-1:0] opb_eff;

  assign opb_eff = req.sub ? ~req.opb : req.opb;
  assign {carry, sum} = {1'b0, req.opa} + {1'b0, opb_eff} + {{WW{1'b0}}, req.sub};

endmodule

// File: rtl/csp_seq.sv
// Sequencer for the final evaluation: scaled dot square, norm product and the
// linear search over odd multipliers, all on one shared adder, plus the result register.
// Depends on csp_pkg and csp_alu.
module csp_seq (
  input  logic                          clk,
  input  logic                          rst,
  input  csp_pkg::sums_t                sums,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [csp_pkg::CODE_W-1:0]    res_code,
  output logic                          res_zero
);
  localparam int AW = csp_pkg::ACC_W;
  localparam int VW = csp_pkg::SCALE_W;
  localparam int WW = csp_pkg::WIDE_W;
  localparam int PW = csp_pkg::NORM_W;
  localparam int CW = csp_pkg::CNT_W;
  localparam int JW = csp_pkg::STEP_W;
  localparam int KW = csp_pkg::CODE_W;

  csp_pkg::seq_state_t state;
  csp_pkg::seq_state_t state_next;
  csp_pkg::alu_req_t   req;

  logic [AW-1:0] mag;
  logic          neg;
  logic [AW-1:0] sa;
  logic [AW-1:0] sb;
  logic [VW-1:0] v;
  logic [WW-1:0] mc;
  logic [VW-1:0] mr;
  logic [WW-1:0] dsq;
  logic [PW-1:0] p;
  logic [PW-1:0] p_next;
  logic [WW-1:0] q;
  logic [WW-1:0] s;
  logic [CW-1:0] cnt;
  logic [JW-1:0] j;
  logic [KW-1:0] code;
  logic          zero;
  logic [WW-1:0] sum;
  logic          carry;
  logic [WW-1:0] mag_w;
  logic [WW-1:0] p_w;
  logic [WW-1:0] p_next_w;
  logic [KW-1:0] j_code;
  logic          final_step;
  logic          emit_take;

  csp_alu u_alu (
    .req   (req),
    .sum   (sum),
    .carry (carry)
  );

  assign mag_w      = {{(WW-AW){1'b0}}, mag};
  assign p_w        = {{(WW-PW){1'b0}}, p};
  assign p_next     = mr[0] ? sum[PW-1:0] : p;
  assign p_next_w   = {{(WW-PW){1'b0}}, p_next};
  assign j_code     = {{(KW-JW){1'b0}}, j};
  assign final_step = (j == JW'(csp_pkg::PERCENT_LIMIT));
  assign emit_take  = (state == csp_pkg::ST_EMIT) && (!res_valid || res_ready);
  assign idle       = (state == csp_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.opa    = '0;
    req.opb    = '0;
    req.sub    = 1'b0;
    case (state)
      csp_pkg::ST_IDLE: begin
        if (sums.valid) begin
          state_next = csp_pkg::ST_CHECK;
        end
      end
      csp_pkg::ST_CHECK: begin
        req.opb    = mag_w;
        req.sub    = 1'b1;
        state_next = (mag == '0) ? csp_pkg::ST_EMIT : csp_pkg::ST_SCALE;
      end
      csp_pkg::ST_SCALE: begin
        req.opa = {{(WW-VW){1'b0}}, v};
        case (cnt[1:0])
          2'd0:    req.opb = mag_w << csp_pkg::SCALE_SHIFT_HI;
          2'd1:    req.opb = mag_w << csp_pkg::SCALE_SHIFT_MD;
          default: req.opb = mag_w << csp_pkg::SCALE_SHIFT_LO;
        endcase
        if (cnt == CW'(csp_pkg::SCALE_STEPS - 1)) begin
          state_next = csp_pkg::ST_SQUARE;
        end
      end
      csp_pkg::ST_SQUARE: begin
        req.opa = dsq;
        req.opb = mc;
        if (cnt == CW'(VW - 1)) begin
          state_next = csp_pkg::ST_NORM;
        end
      end
      csp_pkg::ST_NORM: begin
        req.opa = p_w;
        req.opb = mc;
        if (cnt == CW'(AW - 1)) begin
          state_next = csp_pkg::ST_COMPARE;
        end
      end
      csp_pkg::ST_COMPARE: begin
        req.sub = 1'b1;
        req.opa = neg ? q : dsq;
        req.opb = neg ? dsq : q;
        if (neg) begin
          state_next = (carry || final_step) ? csp_pkg::ST_EMIT : csp_pkg::ST_STEP_Q;
        end else begin
          state_next = (!carry || final_step) ? csp_pkg::ST_EMIT : csp_pkg::ST_STEP_Q;
        end
      end
      csp_pkg::ST_STEP_Q: begin
        req.opa    = q;
        req.opb    = s;
        state_next = csp_pkg::ST_STEP_S;
      end
      csp_pkg::ST_STEP_S: begin
        req.opa    = s;
        req.opb    = p_w << csp_pkg::STEP_SHIFT;
        state_next = csp_pkg::ST_COMPARE;
      end
      csp_pkg::ST_EMIT: begin
        if (!res_valid || res_ready) begin
          state_next = csp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = csp_pkg::ST_IDLE;
      end
    endcase
  end

  // The search walks odd multipliers m = 2j-1 with q = m*m*p and s = 8*j*p.
  always_ff @(posedge clk) begin
    case (state)
      csp_pkg::ST_IDLE: begin
        if (sums.valid) begin
          mag <= sums.dot;
          neg <= sums.dot[AW-1];
          sa  <= sums.norm_a;
          sb  <= sums.norm_b;
        end
      end
      csp_pkg::ST_CHECK: begin
        if (mag == '0) begin
          code <= csp_pkg::CODE_OFFSET;
          zero <= 1'b1;
        end else begin
          zero <= 1'b0;
          if (neg) begin
            mag <= sum[AW-1:0];
          end
          v   <= '0;
          cnt <= '0;
        end
      end
      csp_pkg::ST_SCALE: begin
        v   <= sum[VW-1:0];
        cnt <= cnt + CW'(1);
        if (cnt == CW'(csp_pkg::SCALE_STEPS - 1)) begin
          mc  <= {{(WW-VW){1'b0}}, sum[VW-1:0]};
          mr  <= sum[VW-1:0];
          dsq <= '0;
          cnt <= '0;
        end
      end
      csp_pkg::ST_SQUARE: begin
        if (mr[0]) begin
          dsq <= sum;
        end
        mc  <= mc << 1;
        mr  <= mr >> 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(VW - 1)) begin
          mc  <= {{(WW-AW){1'b0}}, sa};
          mr  <= {{(VW-AW){1'b0}}, sb};
          p   <= '0;
          cnt <= '0;
        end
      end
      csp_pkg::ST_NORM: begin
        p   <= p_next;
        mc  <= mc << 1;
        mr  <= mr >> 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(AW - 1)) begin
          q <= p_next_w;
          s <= p_next_w << csp_pkg::STEP_SHIFT;
          j <= JW'(1);
        end
      end
      csp_pkg::ST_COMPARE: begin
        if (neg) begin
          code <= carry ? (csp_pkg::CODE_OFFSET + KW'(1) - j_code) : csp_pkg::CODE_MIN;
        end else begin
          code <= carry ? csp_pkg::CODE_MAX : (csp_pkg::CODE_OFFSET + j_code - KW'(1));
        end
      end
      csp_pkg::ST_STEP_Q: begin
        q <= sum;
      end
      csp_pkg::ST_STEP_S: begin
        s <= sum;
        j <= j + JW'(1);
      end
      csp_pkg::ST_EMIT: begin
        if (emit_take) begin
          res_code <= code;
          res_zero <= zero;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/cosine_similarity_percent_top.sv
// Top level of the cosine similarity percent block.
// Depends on csp_pkg, csp_in_if, csp_out_if, csp_accum, csp_alu and csp_seq.
//
// Element pairs of two signed Q4.12 vectors are taken one per cycle while the
// block is ready and summed into the dot product and the two sums of squares; the
// pair marked last closes the vectors and yields one result, the rounded cosine in
// percent plus 128, held in a result register until taken. From the last pair the
// block takes no new request until the sequencer is back in idle, which waits for
// any earlier result to be taken. The evaluation runs on the single shared 112-bit
// adder, which forms the scaled dot square and the norm product one bit a cycle and
// then walks the rounding thresholds, up to 100 of them, each by a compare, a step
// of q and a step of s; when the dot product is zero the search is skipped.
module cosine_similarity_percent_top (
  input  logic        clk,
  input  logic        rst,
  csp_in_if.sink      item,
  csp_out_if.source   result
);
  csp_pkg::sums_t sums;
  logic           idle;
  logic           pend;
  logic           take;

  assign item.ready = idle && !pend;
  assign take       = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (take && item.last) begin
      pend <= 1'b1;
    end else if (sums.valid) begin
      pend <= 1'b0;
    end
  end

  csp_accum u_accum (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .first_element  (item.first_element),
    .second_element (item.second_element),
    .last           (item.last),
    .sums           (sums)
  );

  csp_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .sums      (sums),
    .idle      (idle),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_code  (result.similarity_code),
    .res_zero  (result.zero_dot)
  );

endmodule
